/* rtl/ins_pkg.sv */
// Package for the insertion sorter: data width, default depth, controller
// state type and the control group handed to the cell chain.
// No dependencies.
package ins_pkg;

   localparam int VALUE_W       = 32;
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_EMIT
   } state_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // place the incoming value, larger ones move up
      logic shift;    // move every value one cell towards cell 0
   } cell_ctrl_type;

endpackage

/* rtl/ins_cell.sv */
// One compare-and-shift cell of the sorting chain.
// Depends on ins_pkg.
module ins_cell (
   input  logic                                clock,
   input  ins_pkg::cell_ctrl_type              ctrl,
   input  logic                                occupied,
   input  logic signed [ins_pkg::VALUE_W-1:0]  new_value,
   input  logic                                left_gt,
   input  logic signed [ins_pkg::VALUE_W-1:0]  left_value,
   input  logic signed [ins_pkg::VALUE_W-1:0]  right_value,
   output logic                                gt,
   output logic signed [ins_pkg::VALUE_W-1:0]  value
);

   logic signed [ins_pkg::VALUE_W-1:0] value_ff;
   logic signed [ins_pkg::VALUE_W-1:0] value_in;

   // an empty cell counts as larger than anything
   assign gt    = !occupied || (value_ff > new_value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.shift) begin
         value_in = right_value;
      end else if (ctrl.insert && gt) begin
         value_in = left_gt ? left_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* rtl/ins_ctrl.sv */
// Controller of the insertion sorter: load/emit sequencing, fill count
// and overflow flag. Depends on ins_pkg.
module ins_ctrl #(
   parameter int DEPTH = ins_pkg::DEPTH_DEFAULT,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_last,
   output logic                   rsp_overflow,
   output ins_pkg::cell_ctrl_type ctrl,
   output logic [CW-1:0]          count
);

   localparam logic [CW-1:0] FULL = CW'(DEPTH);
   localparam logic [CW-1:0] ONE  = CW'(1);

   ins_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               drop_ff, drop_in;
   logic               req_acc, rsp_acc, full;

   assign full    = (count_ff == FULL);
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign count   = count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ins_pkg::ST_LOAD: if (req_acc && req_tlast) state_in = ins_pkg::ST_EMIT;
         ins_pkg::ST_EMIT: if (rsp_acc && count_ff == ONE) state_in = ins_pkg::ST_LOAD;
         default:          state_in = ins_pkg::ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      ctrl.insert = 1'b0;
      ctrl.shift  = 1'b0;
      unique case (state_ff)
         ins_pkg::ST_LOAD: begin
            req_tready  = 1'b1;
            ctrl.insert = req_tvalid && !full;
         end
         ins_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            ctrl.shift = rsp_tready;
         end
         default: ;
      endcase
   end

   assign rsp_last     = (count_ff == ONE);
   assign rsp_overflow = drop_ff;

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      if (req_acc) begin
         if (full) drop_in  = 1'b1;
         else      count_in = count_ff + ONE;
      end
      if (rsp_acc) begin
         count_in = count_ff - ONE;
         if (count_ff == ONE) drop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ins_pkg::ST_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

/* rtl/insertion_sorter_unit.sv */
// Top level of the insertion sorter: a chain of DEPTH compare-and-shift
// cells and its controller. Depends on ins_pkg, ins_cell and ins_ctrl.
//
// Usage
//   req channel: one signed 32-bit value per request, tlast closes the set.
//   rsp channel: the stored values in ascending order, tlast on the largest,
//   tuser set on every result of a set that lost values to overflow.
//   Loading takes one request per cycle: each value is compared against all
//   cells at once and larger values move one cell up in the same cycle.
//   A set holds at most DEPTH values; later ones are dropped and flagged.
//   The first result is offered the cycle after the tlast request.
//   Emission gives one result per cycle while rsp_tready is high, shifting
//   the chain towards cell 0; while a set drains, req_tready is low.
//   Loading resumes the cycle after the final result is taken.
//   Receiver stall: the chain holds still and the offered result stays
//   put until rsp_tready rises.
//   Reset (synchronous, active high) empties the store and clears the
//   overflow flag; cell contents are not cleared, the fill count guards
//   them.
module insertion_sorter_unit #(
   parameter int DEPTH = ins_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,   // last_res
   output logic        rsp_tuser    // [0] overflow
);

   localparam int CW = $clog2(DEPTH + 1);

   ins_pkg::cell_ctrl_type             ctrl;
   logic [CW-1:0]                      count;
   logic                               gt  [DEPTH];
   logic signed [ins_pkg::VALUE_W-1:0] val [DEPTH];
   logic signed [ins_pkg::VALUE_W-1:0] new_value;

   assign new_value = $signed(req_tdata);

   ins_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tlast    (req_tlast),
      .req_tready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_last     (rsp_tlast),
      .rsp_overflow (rsp_tuser),
      .ctrl         (ctrl),
      .count        (count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      logic                               occ;
      logic                               l_gt;
      logic signed [ins_pkg::VALUE_W-1:0] l_val, r_val;

      assign occ = (IDX < count);

      if (i == 0) begin : g_first
         assign l_gt  = 1'b0;
         assign l_val = new_value;
      end else begin : g_mid
         assign l_gt  = gt[i-1];
         assign l_val = val[i-1];
      end

      // the top cell refills with its own value; it lies beyond the count
      if (i == DEPTH - 1) begin : g_top
         assign r_val = val[i];
      end else begin : g_low
         assign r_val = val[i+1];
      end

      ins_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ),
         .new_value   (new_value),
         .left_gt     (l_gt),
         .left_value  (l_val),
         .right_value (r_val),
         .gt          (gt[i]),
         .value       (val[i])
      );
   end

   // cell 0 always holds the smallest remaining value
   assign rsp_tdata = val[0];

endmodule
